// ===== rtl/core/cdp_frame_tlv_parser_unit_defines.svh =====
// assertion helpers for the cdp parser
`ifndef CDP_FRAME_TLV_PARSER_UNIT_DEFINES_SVH
`define CDP_FRAME_TLV_PARSER_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CDP_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication outside reset
`define CDP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/cdp_pkg.sv =====
package cdp_pkg;

    localparam logic [47:0] MAC_RESET     = 48'h01000CCCCCCC;
    localparam logic [15:0] PAYLOAD_START = 16'd22;
    localparam logic [15:0] TLV_START     = 16'd26;
    localparam logic [7:0]  NLPID_IPV4    = 8'hCC;
    localparam logic [15:0] ADDR_MIN_DATA = 16'd13;

    localparam logic [15:0] TLV_DEVICE   = 16'd1;
    localparam logic [15:0] TLV_ADDRESS  = 16'd2;
    localparam logic [15:0] TLV_PORT     = 16'd3;
    localparam logic [15:0] TLV_CAPS     = 16'd4;
    localparam logic [15:0] TLV_VERSION  = 16'd5;
    localparam logic [15:0] TLV_PLATFORM = 16'd6;
    localparam logic [15:0] TLV_VTP      = 16'd9;
    localparam logic [15:0] TLV_VLAN     = 16'd10;
    localparam logic [15:0] TLV_DUPLEX   = 16'd11;

    localparam logic [2:0] SID_DEVICE   = 3'd0;
    localparam logic [2:0] SID_PORT     = 3'd1;
    localparam logic [2:0] SID_VERSION  = 3'd2;
    localparam logic [2:0] SID_PLATFORM = 3'd3;
    localparam logic [2:0] SID_VTP      = 3'd4;

    localparam logic KIND_STRING  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [15:0] frame_length;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  string_id;
        logic [5:0]  char_index;
        logic [7:0]  char_value;
        logic        is_cdp;
        logic [7:0]  proto_version;
        logic [7:0]  cdp_ttl;
        logic [31:0] capability_bits;
        logic [15:0] vlan_id;
        logic [7:0]  duplex_mode;
        logic [31:0] mgmt_ipv4;
        logic        neighbor_valid;
    } out_item_t;

    // result of processing one byte
    typedef struct packed {
        logic      str_valid;
        out_item_t str_item;
        logic      sum_valid;
        out_item_t sum_item;
    } step_res_t;

    function automatic logic [7:0] snap_byte(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'hAA;
            3'd1: r = 8'hAA;
            3'd2: r = 8'h03;
            3'd3: r = 8'h00;
            3'd4: r = 8'h00;
            3'd5: r = 8'h0C;
            3'd6: r = 8'h20;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cdp_if.sv =====
interface cdp_in_if;
    import cdp_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdp_out_if;
    import cdp_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdp_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cdp_parse.sv =====
module cdp_byte_walker
    import cdp_pkg::*;
#(
    parameter int MAX_STRING = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [47:0] mac,
    output step_res_t   res
);

    localparam logic [15:0] STR_LIMIT = 16'(MAX_STRING - 1);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] nts_reg, nts_next;
    logic [15:0] typ_reg, typ_next;
    logic [15:0] tlen_reg, tlen_next;
    logic        hdr_reg, hdr_next;
    logic        stop_reg, stop_next;
    logic [31:0] shf_reg, shf_next;
    logic        am_reg, am_next;
    logic [63:0] sf_reg, sf_next;
    logic [63:0] sm_reg, sm_next;
    logic [7:0]  dfb_reg, dfb_next;

    logic [7:0]  b;
    logic [15:0] len;
    logic [7:0]  mb;
    logic        cdp_ok, is_cdp, has_hdr, sid_ok;
    logic [2:0]  sid;
    logic [15:0] h, d, dl, ctl;
    logic [16:0] s4, send;

    always_comb
    begin
        b = item.byte_value;
        len = item.frame_length;
        pos_next = pos_reg; nts_next = nts_reg; typ_next = typ_reg;
        tlen_next = tlen_reg; hdr_next = hdr_reg; stop_next = stop_reg;
        shf_next = shf_reg; am_next = am_reg; sf_next = sf_reg;
        sm_next = sm_reg; dfb_next = dfb_reg;
        res = '0;
        mb = '0; sid = '0; sid_ok = 1'b0;
        h = pos_reg - nts_reg;
        d = pos_reg - (nts_reg - tlen_reg) - 16'd4;
        ctl = '0; dl = '0;
        s4 = {1'b0, nts_reg} + 17'd4;
        send = '0;

        // destination mac and snap header
        if (pos_reg < 16'd6)
        begin
            mb = mac[8 * (5 - pos_reg[2:0]) +: 8];
            am_next = (pos_reg == 16'd0) ? (b == mb) : (am_reg && b == mb);
        end
        if (pos_reg >= 16'd14 && pos_reg <= 16'd21 && b != snap_byte(3'(pos_reg - 16'd14)))
            hdr_next = 1'b0;
        cdp_ok = am_next && hdr_next;

        if (pos_reg == PAYLOAD_START) sf_next[7:0] = b;
        if (pos_reg == PAYLOAD_START + 16'd1) sf_next[15:8] = b;
        if (pos_reg == TLV_START - 16'd1) nts_next = TLV_START;

        // string type lookup
        unique case (typ_reg)
            TLV_DEVICE:   begin sid = SID_DEVICE;   sid_ok = 1'b1; end
            TLV_PORT:     begin sid = SID_PORT;     sid_ok = 1'b1; end
            TLV_VERSION:  begin sid = SID_VERSION;  sid_ok = 1'b1; end
            TLV_PLATFORM: begin sid = SID_PLATFORM; sid_ok = 1'b1; end
            TLV_VTP:      begin sid = SID_VTP;      sid_ok = 1'b1; end
            default:      begin sid = SID_DEVICE;   sid_ok = 1'b0; end
        endcase

        // tlv walk
        if (cdp_ok && pos_reg >= TLV_START && !stop_reg)
        begin
            if (pos_reg >= nts_reg)
            begin
                if (h == 16'd0)
                begin
                    if (s4 > {1'b0, len}) stop_next = 1'b1;
                    else typ_next = {b, 8'h00};
                end
                else if (h == 16'd1)
                    typ_next = {typ_reg[15:8], b};
                else if (h == 16'd2)
                    tlen_next = {b, 8'h00};
                else if (h == 16'd3)
                begin
                    ctl = {tlen_reg[15:8], b};
                    tlen_next = ctl;
                    send = {1'b0, nts_reg} + {1'b0, ctl};
                    if (ctl < 16'd4 || send > {1'b0, len})
                        stop_next = 1'b1;
                    else
                    begin
                        dl = ctl - 16'd4;
                        if ((typ_reg == TLV_ADDRESS && dl < ADDR_MIN_DATA) ||
                            (typ_reg == TLV_CAPS && dl < 16'd4) ||
                            (typ_reg == TLV_VLAN && dl < 16'd2))
                            typ_next = '0;
                        shf_next = '0;
                        nts_next = send[15:0];
                    end
                end
                else
                    stop_next = 1'b1;
            end
            else if (sid_ok)
            begin
                if (sid == SID_DEVICE && d == 16'd0) dfb_next = b;
                if (d < STR_LIMIT)
                begin
                    res.str_valid = 1'b1;
                    res.str_item.result_kind = KIND_STRING;
                    res.str_item.string_id = sid;
                    res.str_item.char_index = d[5:0];
                    res.str_item.char_value = b;
                end
            end
            else if (typ_reg == TLV_ADDRESS)
            begin
                if ((d == 16'd4 && b != 8'd1) || (d == 16'd5 && b != 8'd1) ||
                    (d == 16'd6 && b != NLPID_IPV4) || (d == 16'd7 && b != 8'd0) ||
                    (d == 16'd8 && b != 8'd4))
                    typ_next = '0;
                else if (d >= 16'd9 && d <= 16'd12)
                begin
                    shf_next = {shf_reg[23:0], b};
                    if (d == 16'd12) sm_next[31:0] = shf_next;
                end
            end
            else if (typ_reg == TLV_CAPS)
            begin
                if (d <= 16'd3)
                begin
                    shf_next = {shf_reg[23:0], b};
                    if (d == 16'd3) sf_next[63:32] = shf_next;
                end
            end
            else if (typ_reg == TLV_VLAN)
            begin
                if (d <= 16'd1)
                begin
                    shf_next = {16'h0, shf_reg[7:0], b};
                    if (d == 16'd1) sf_next[31:16] = shf_next[15:0];
                end
            end
            else if (typ_reg == TLV_DUPLEX)
            begin
                if (d == 16'd0) sm_next[39:32] = b;
            end
        end

        // end of frame summary
        is_cdp = cdp_ok && len >= PAYLOAD_START;
        has_hdr = is_cdp && len >= TLV_START;
        if ({1'b0, pos_reg} + 17'd1 >= {1'b0, len})
        begin
            res.sum_valid = 1'b1;
            res.sum_item.result_kind = KIND_SUMMARY;
            res.sum_item.is_cdp = is_cdp;
            res.sum_item.proto_version = has_hdr ? sf_next[7:0] : 8'h0;
            res.sum_item.cdp_ttl = has_hdr ? sf_next[15:8] : 8'h0;
            if (is_cdp)
            begin
                res.sum_item.capability_bits = sf_next[63:32];
                res.sum_item.vlan_id = sf_next[31:16];
                res.sum_item.duplex_mode = sm_next[39:32];
                res.sum_item.mgmt_ipv4 = sm_next[31:0];
                res.sum_item.neighbor_valid = (dfb_next != 8'h0);
            end
            pos_next = '0; nts_next = '0; typ_next = '0; tlen_next = '0;
            hdr_next = 1'b1; stop_next = 1'b0; shf_next = '0; am_next = 1'b0;
            sf_next = '0; sm_next = '0; dfb_next = '0;
        end
        else
            pos_next = pos_reg + 16'd1;
    end

    // per-frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; nts_reg <= '0; typ_reg <= '0; tlen_reg <= '0;
            hdr_reg <= 1'b1; stop_reg <= 1'b0; shf_reg <= '0; am_reg <= 1'b0;
            sf_reg <= '0; sm_reg <= '0; dfb_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next; nts_reg <= nts_next; typ_reg <= typ_next;
            tlen_reg <= tlen_next; hdr_reg <= hdr_next; stop_reg <= stop_next;
            shf_reg <= shf_next; am_reg <= am_next; sf_reg <= sf_next;
            sm_reg <= sm_next; dfb_reg <= dfb_next;
        end
    end

endmodule

// ===== rtl/core/cdp_outq.sv =====
`include "cdp_frame_tlv_parser_unit_defines.svh"

module cdp_outq
    import cdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_res_t res,
    output logic      space,
    cdp_out_if.source out_ch
);

    // four-entry fifo, up to two writes per request
    out_item_t   mem_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pop;
    logic [1:0]  nw;

    assign pop = out_ch.valid && out_ch.ready;
    assign nw = push ? (2'(res.str_valid) + 2'(res.sum_valid)) : 2'd0;
    assign cnt_next = cnt_reg + 3'(nw) - 3'(pop);
    assign space = (cnt_reg <= 3'd2);
    assign out_ch.valid = (cnt_reg != 3'd0);
    assign out_ch.data = mem_reg[rp_reg];

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push && res.str_valid)
            mem_reg[wp_reg] <= res.str_item;
        if (push && res.sum_valid)
            mem_reg[wp_reg + 2'(res.str_valid)] <= res.sum_item;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + nw;
            rp_reg <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    `CDP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_reg <= 3'd2, "queue overflow on push")
    `CDP_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= 3'd4, "queue count out of range")
    `CDP_ASSERT_NEXT(a_idle_empty, clk, rst_n, cnt_reg == 3'd0 && !push, !out_ch.valid,
        "output valid without request")

endmodule

// ===== rtl/core/cdp_frame_tlv_parser_unit.sv =====
// channel    | role  | payload
// in_ch      | sink  | byte_value, frame_length
// cfg_ch     | sink  | neighbor_mac (48 bits)
// out_ch     | source| string byte or frame summary
// one byte is taken per cycle while the queue has room; its results appear in the queue the next cycle
// a byte gives at most two results; the four-entry output queue sets the stall
// in_ch.ready drops when fewer than two queue entries are free
// reset clears the frame walk and loads the default neighbor mac
`include "cdp_frame_tlv_parser_unit_defines.svh"

module cdp_frame_tlv_parser_unit
    import cdp_pkg::*;
#(
    parameter int MAX_STRING = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    cdp_in_if.sink   in_ch,
    cdp_cfg_if.sink  cfg_ch,
    cdp_out_if.source out_ch
);

    logic [47:0] mac_reg;
    logic        space, step;
    step_res_t   res;

    // config register
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_reg <= MAC_RESET;
        else if (cfg_ch.valid)
            mac_reg <= cfg_ch.data;
    end

    assign in_ch.ready = space;
    assign step = in_ch.valid && space;

    cdp_byte_walker #(.MAX_STRING(MAX_STRING)) u_parse (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_ch.data),
        .mac(mac_reg), .res(res)
    );

    cdp_outq u_outq (
        .clk(clk), .rst_n(rst_n), .push(step), .res(res), .space(space),
        .out_ch(out_ch)
    );

    `CDP_ASSERT_NEXT(a_sum_queued, clk, rst_n, step && res.sum_valid, out_ch.valid,
        "summary not queued")
    `CDP_ASSERT_IMP(a_kind, clk, rst_n, step && res.sum_valid, res.sum_item.result_kind,
        "summary without kind flag")
    `CDP_ASSERT_IMP(a_str_kind, clk, rst_n, step && res.str_valid, !res.str_item.result_kind,
        "string byte with summary flag")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import cdp_pkg::*;

    logic clk;
    logic rst_n;

    cdp_in_if  in_ch();
    cdp_cfg_if cfg_ch();
    cdp_out_if out_ch();

    cdp_frame_tlv_parser_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    localparam int STR_LIMIT   = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        in_item_t data;
        bit       drain;
    } pending_t;

    pending_t   send_q[$];
    out_item_t  expected_q[$];
    logic [7:0] frame_buf[$];

    // parser mirror state
    logic [47:0] mac_reg;
    int          pos;
    int          tlv_next;
    logic [15:0] cur_type;
    logic [15:0] tlv_len;
    logic        hdr_ok;
    logic        walk_done;
    logic [31:0] shift_acc;
    logic        mac_hit;
    logic [7:0]  hdr_ver;
    logic [7:0]  hdr_ttl;
    logic [15:0] vlan_val;
    logic [31:0] caps_val;
    logic [31:0] ip_val;
    logic [7:0]  duplex_val;
    logic [7:0]  device_b0;

    logic [7:0] snap_ref [8] = '{8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h0C, 8'h20, 8'h00};

    int  errors = 0;
    int  cycles = 0;
    int  send_pct;
    int  recv_pct;
    int  long_hold = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  in_taken;
    int  bytes_sent = 0;
    int  frames_sent;
    int  strings_seen = 0;
    int  summaries_seen = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic clear_walk();
        pos = 0;
        tlv_next = 0;
        cur_type = '0;
        tlv_len = '0;
        hdr_ok = 1'b1;
        walk_done = 1'b0;
        shift_acc = '0;
        mac_hit = 1'b0;
        hdr_ver = '0;
        hdr_ttl = '0;
        vlan_val = '0;
        caps_val = '0;
        ip_val = '0;
        duplex_val = '0;
        device_b0 = '0;
    endtask

    // compare one result field
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s exp %0h got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // value byte inside a tlv
    task automatic tlv_value_byte(input int d, input logic [7:0] b);
        out_item_t r;
        logic [2:0] sid;
        bit is_str;
        r = '0;
        is_str = 1'b1;
        case (cur_type)
            TLV_DEVICE:   sid = SID_DEVICE;
            TLV_PORT:     sid = SID_PORT;
            TLV_VERSION:  sid = SID_VERSION;
            TLV_PLATFORM: sid = SID_PLATFORM;
            TLV_VTP:      sid = SID_VTP;
            default:
            begin
                sid = SID_DEVICE;
                is_str = 1'b0;
            end
        endcase
        if (is_str)
        begin
            if (cur_type == TLV_DEVICE && d == 0)
                device_b0 = b;
            if (d < STR_LIMIT - 1)
            begin
                r.result_kind = KIND_STRING;
                r.string_id = sid;
                r.char_index = d[5:0];
                r.char_value = b;
                expected_q.push_back(r);
            end
        end
        else if (cur_type == TLV_ADDRESS)
        begin
            if ((d == 4 && b != 8'd1) || (d == 5 && b != 8'd1) || (d == 6 && b != NLPID_IPV4)
                || (d == 7 && b != 8'd0) || (d == 8 && b != 8'd4))
                cur_type = '0;
            else if (d >= 9 && d <= 12)
            begin
                shift_acc = {shift_acc[23:0], b};
                if (d == 12)
                    ip_val = shift_acc;
            end
        end
        else if (cur_type == TLV_CAPS)
        begin
            if (d <= 3)
            begin
                shift_acc = {shift_acc[23:0], b};
                if (d == 3)
                    caps_val = shift_acc;
            end
        end
        else if (cur_type == TLV_VLAN)
        begin
            if (d <= 1)
            begin
                shift_acc = {16'd0, shift_acc[7:0], b};
                if (d == 1)
                    vlan_val = shift_acc[15:0];
            end
        end
        else if (cur_type == TLV_DUPLEX)
        begin
            if (d == 0)
                duplex_val = b;
        end
    endtask

    // expected results of one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic [15:0] len);
        int p;
        int s;
        int h;
        logic ok;
        logic cdp;
        logic hdr;
        logic [7:0] mb;
        out_item_t r;
        p = pos;
        if (p < 6)
        begin
            mb = mac_reg[8*(5-p) +: 8];
            mac_hit = (p == 0) ? (b == mb) : (mac_hit && b == mb);
        end
        if (p >= 14 && p <= 21 && b != snap_ref[p-14])
            hdr_ok = 1'b0;
        ok = mac_hit && hdr_ok;
        if (p == PAYLOAD_START)
            hdr_ver = b;
        if (p == PAYLOAD_START + 1)
            hdr_ttl = b;
        if (p == TLV_START - 1)
            tlv_next = TLV_START;
        // tlv walk
        if (ok && p >= TLV_START && !walk_done)
        begin
            s = tlv_next;
            if (p >= s)
            begin
                h = p - s;
                if (h == 0)
                begin
                    if (s + 4 > len)
                        walk_done = 1'b1;
                    else
                        cur_type = {b, 8'h00};
                end
                else if (h == 1)
                    cur_type[7:0] = b;
                else if (h == 2)
                    tlv_len = {b, 8'h00};
                else if (h == 3)
                begin
                    tlv_len[7:0] = b;
                    if (tlv_len < 4 || s + tlv_len > len)
                        walk_done = 1'b1;
                    else
                    begin
                        if ((cur_type == TLV_ADDRESS && tlv_len - 4 < ADDR_MIN_DATA)
                            || (cur_type == TLV_CAPS && tlv_len < 8)
                            || (cur_type == TLV_VLAN && tlv_len < 6))
                            cur_type = '0;
                        shift_acc = '0;
                        tlv_next = s + tlv_len;
                    end
                end
                else
                    walk_done = 1'b1;
            end
            else
                tlv_value_byte(p - (s - tlv_len) - 4, b);
        end
        // end of frame summary
        if (p + 1 >= len)
        begin
            cdp = ok && len >= PAYLOAD_START;
            hdr = cdp && len >= TLV_START;
            r = '0;
            r.result_kind = KIND_SUMMARY;
            r.is_cdp = cdp;
            r.proto_version = hdr ? hdr_ver : 8'd0;
            r.cdp_ttl = hdr ? hdr_ttl : 8'd0;
            if (cdp)
            begin
                r.capability_bits = caps_val;
                r.vlan_id = vlan_val;
                r.duplex_mode = duplex_val;
                r.mgmt_ipv4 = ip_val;
                r.neighbor_valid = (device_b0 != 8'd0);
            end
            expected_q.push_back(r);
            clear_walk();
        end
        else
            pos = p + 1;
    endtask

    // sample accepted requests and results
    always @(posedge clk)
    begin
        out_item_t e;
        out_item_t a;
        if (!rst_n)
        begin
            in_taken = 1'b0;
            mac_reg = MAC_RESET;
            clear_walk();
        end
        else
        begin
            in_taken = in_ch.valid && in_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
                mac_reg = cfg_ch.data;
            if (out_ch.valid && out_ch.ready)
            begin
                a = out_ch.data;
                if (a.result_kind == KIND_SUMMARY)
                    summaries_seen++;
                else
                    strings_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result %p", a);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("result_kind", 32'(e.result_kind), 32'(a.result_kind));
                    check_field("string_id", 32'(e.string_id), 32'(a.string_id));
                    check_field("char_index", 32'(e.char_index), 32'(a.char_index));
                    check_field("char_value", 32'(e.char_value), 32'(a.char_value));
                    check_field("is_cdp", 32'(e.is_cdp), 32'(a.is_cdp));
                    check_field("proto_version", 32'(e.proto_version),
                                32'(a.proto_version));
                    check_field("cdp_ttl", 32'(e.cdp_ttl), 32'(a.cdp_ttl));
                    check_field("capability_bits", e.capability_bits, a.capability_bits);
                    check_field("vlan_id", 32'(e.vlan_id), 32'(a.vlan_id));
                    check_field("duplex_mode", 32'(e.duplex_mode), 32'(a.duplex_mode));
                    check_field("mgmt_ipv4", e.mgmt_ipv4, a.mgmt_ipv4);
                    check_field("neighbor_valid", 32'(e.neighbor_valid),
                                32'(a.neighbor_valid));
                end
            end
            if (in_taken)
            begin
                bytes_sent++;
                parse_byte(in_ch.data.byte_value, in_ch.data.frame_length);
            end
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else if (!(in_ch.valid && !in_taken))
        begin
            if (send_q.size() > 0 && !(send_q[0].drain && expected_q.size() > 0)
                && !($urandom_range(99) < send_pct))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= send_q[0].data;
                void'(send_q.pop_front());
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result receiver with a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            long_hold++;
            if (long_hold >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
            out_ch.ready <= !($urandom_range(99) < recv_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_frame(input logic [15:0] len, input int count, input bit drain);
        pending_t it;
        for (int i = 0; i < count; i++)
        begin
            it.data.byte_value = frame_buf[i];
            it.data.frame_length = len;
            it.drain = drain && (i == 0);
            send_q.push_back(it);
        end
        frames_sent++;
    endtask

    task automatic push_tlv(input logic [15:0] t, input logic [15:0] l);
        frame_buf.push_back(t[15:8]);
        frame_buf.push_back(t[7:0]);
        frame_buf.push_back(l[15:8]);
        frame_buf.push_back(l[7:0]);
    endtask

    // random cdp frame, mostly well formed
    task automatic build_frame(input logic [47:0] mac, input bit drain);
        int ntlv;
        int dl;
        int kind;
        int bad;
        int len;
        logic [15:0] t;
        frame_buf.delete();
        for (int i = 0; i < 6; i++)
            frame_buf.push_back(($urandom_range(11) == 0) ? 8'($urandom) : mac[8*(5-i) +: 8]);
        repeat (8) frame_buf.push_back(8'($urandom));
        for (int i = 0; i < 8; i++)
            frame_buf.push_back(($urandom_range(15) == 0) ? 8'($urandom) : snap_ref[i]);
        repeat (4) frame_buf.push_back(8'($urandom));
        ntlv = $urandom_range(1, 6);
        for (int n = 0; n < ntlv; n++)
        begin
            kind = $urandom_range(7);
            case (kind)
                0, 1:
                begin
                    case ($urandom_range(4))
                        0: t = TLV_DEVICE;
                        1: t = TLV_PORT;
                        2: t = TLV_VERSION;
                        3: t = TLV_PLATFORM;
                        default: t = TLV_VTP;
                    endcase
                    dl = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
                    push_tlv(t, 16'(dl + 4));
                    for (int i = 0; i < dl; i++)
                        frame_buf.push_back((i == 0 && $urandom_range(4) == 0) ? 8'd0 : 8'($urandom));
                end
                2:
                begin
                    dl = ($urandom_range(5) == 0) ? $urandom_range(9, 12) : $urandom_range(13, 20);
                    push_tlv(TLV_ADDRESS, 16'(dl + 4));
                    bad = ($urandom_range(3) == 0) ? $urandom_range(4, 8) : 99;
                    for (int i = 0; i < dl; i++)
                    begin
                        case (i)
                            4, 5: frame_buf.push_back(8'd1);
                            6: frame_buf.push_back(NLPID_IPV4);
                            7: frame_buf.push_back(8'd0);
                            8: frame_buf.push_back(8'd4);
                            default: frame_buf.push_back(8'($urandom));
                        endcase
                        if (i == bad)
                            frame_buf[frame_buf.size()-1] = 8'($urandom);
                    end
                end
                3, 4, 5:
                begin
                    t = (kind == 3) ? TLV_CAPS : (kind == 4) ? TLV_VLAN : TLV_DUPLEX;
                    dl = (kind == 3) ? 4 : (kind == 4) ? 2 : 1;
                    if ($urandom_range(5) == 0)
                        dl = $urandom_range(0, 6);
                    push_tlv(t, 16'(dl + 4));
                    repeat (dl) frame_buf.push_back(8'($urandom));
                end
                6:
                begin
                    dl = $urandom_range(0, 6);
                    push_tlv(16'($urandom), 16'(dl + 4));
                    repeat (dl) frame_buf.push_back(8'($urandom));
                end
                default:
                begin
                    // broken length field
                    push_tlv(TLV_DEVICE, ($urandom_range(1) == 0) ? 16'($urandom_range(3))
                             : 16'($urandom_range(100, 65535)));
                    repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
                end
            endcase
        end
        repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
        len = frame_buf.size();
        if ($urandom_range(9) == 0)
            len = $urandom_range(1, len);
        queue_frame(16'(len), len, drain);
    endtask

    // random noise frame
    task automatic build_noise();
        int len;
        frame_buf.delete();
        len = $urandom_range(1, 40);
        repeat (len) frame_buf.push_back(8'($urandom));
        queue_frame(16'(len), len, 1'b0);
    endtask

    task automatic write_mac(input logic [47:0] v);
        wait (send_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus and run control
    initial
    begin
        logic [47:0] macs [4];
        pending_t it;
        int phase_bytes;
        send_pct = 0;
        recv_pct = 0;
        frames_sent = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: one-byte frame, then a max length frame cut short by a shrinking length
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        queue_frame(16'd1, 1, 1'b0);
        frame_buf.delete();
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        queue_frame(16'hFFFF, 2, 1'b0);
        frame_buf.delete();
        frame_buf.push_back(8'h5A);
        queue_frame(16'd2, 1, 1'b0);
        build_frame(MAC_RESET, 1'b0);

        macs[0] = MAC_RESET;
        macs[1] = 48'hFFFFFFFFFFFF;
        macs[2] = 48'h000000000000;
        macs[3] = {16'($urandom), 32'($urandom)};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mac(macs[ph]);
            send_pct = (ph == 1) ? 59 : (ph == 3) ? 18 : 0;
            recv_pct = (ph == 2) ? 59 : (ph == 3) ? 18 : 0;
            if (ph == 0)
                hold_req = 1'b1;
            phase_bytes = send_q.size() + bytes_sent;
            for (int f = 0; send_q.size() + bytes_sent - phase_bytes < 340; f++)
            begin
                if ($urandom_range(6) == 0)
                    build_noise();
                else
                    build_frame(macs[ph], (f % 6) == 3);
            end
        end

        wait (send_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d bytes in %0d frames over 4 neighbor addresses and idle patterns",
                 bytes_sent, frames_sent);
        $display("checked %0d string bytes and %0d frame summaries", strings_seen, summaries_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cdp_pkg.sv
rtl/core/cdp_if.sv
rtl/core/cdp_parse.sv
rtl/core/cdp_outq.sv
rtl/core/cdp_frame_tlv_parser_unit.sv
sim/tb.sv
